/* rtl/qla_pkg.sv */
// ----------------------------------------------------------------------------
// qla_pkg
// Types, constants and the control program shared by the Q-table agent.
// ----------------------------------------------------------------------------
package qla_pkg;

  // Field widths
  localparam int OpW   = 2;
  localparam int StW   = 4;
  localparam int ActW  = 2;
  localparam int ValW  = 16;
  localparam int RegW  = 16;
  localparam int PctW  = 7;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EXPLORE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LRATE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISCOUNT = 2'd2;

  // Register reset values
  localparam logic [RegW-1:0] ExploreRst  = 16'd6554;
  localparam logic [RegW-1:0] LrateRst    = 16'd6554;
  localparam logic [RegW-1:0] DiscountRst = 16'd58982;

  // Exploration percent split
  localparam logic [PctW-1:0] PctLow  = 7'd30;
  localparam logic [PctW-1:0] PctHigh = 7'd85;

  typedef enum logic [OpW-1:0] {
    OP_CHOOSE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_WRITE  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic [StW-1:0]         state;
    logic signed [StW-1:0]  next_state;
    logic [ActW-1:0]        action;
    logic signed [ValW-1:0] reward;
    logic signed [ValW-1:0] write_value;
    logic [RegW-1:0]        random_draw;
    logic [PctW-1:0]        random_percent;
  } in_item_t;

  typedef struct packed {
    logic [ActW-1:0]        chosen_action;
    logic                   explored;
    logic signed [ValW-1:0] new_value;
    logic                   update_skipped;
  } out_item_t;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_SCAN,
    UOP_RDQ,
    UOP_MULG,
    UOP_DIFF,
    UOP_MULL,
    UOP_MULH,
    UOP_SUM,
    UOP_FIN_CHOOSE,
    UOP_FIN_EXPL,
    UOP_FIN_UPD,
    UOP_FIN_SKIP,
    UOP_FIN_WR,
    UOP_FIN_NOP
  } uop_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_EXPLORE,
    COND_SKIP,
    COND_LOOP
  } cond_e;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
    logic  done;
  } ctrl_t;

  // Program entry points
  localparam upc_t EntryChoose = 4'd0;
  localparam upc_t EntryExpl   = 4'd3;
  localparam upc_t EntryUpdate = 4'd4;
  localparam upc_t EntrySkip   = 4'd13;
  localparam upc_t EntryWrite  = 4'd14;
  localparam upc_t EntryNop    = 4'd15;

  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t w;
    w = '{op: UOP_NOP, cond: COND_NEXT, target: '0, done: 1'b0};
    case (pc)
      4'd0:  w = '{op: UOP_NOP,        cond: COND_EXPLORE, target: EntryExpl, done: 1'b0};
      4'd1:  w = '{op: UOP_SCAN,       cond: COND_LOOP,    target: 4'd1,      done: 1'b0};
      4'd2:  w = '{op: UOP_FIN_CHOOSE, cond: COND_NEXT,    target: '0,        done: 1'b1};
      4'd3:  w = '{op: UOP_FIN_EXPL,   cond: COND_NEXT,    target: '0,        done: 1'b1};
      4'd4:  w = '{op: UOP_NOP,        cond: COND_SKIP,    target: EntrySkip, done: 1'b0};
      4'd5:  w = '{op: UOP_SCAN,       cond: COND_LOOP,    target: 4'd5,      done: 1'b0};
      4'd6:  w = '{op: UOP_RDQ,        cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd7:  w = '{op: UOP_MULG,       cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd8:  w = '{op: UOP_DIFF,       cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd9:  w = '{op: UOP_MULL,       cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd10: w = '{op: UOP_MULH,       cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd11: w = '{op: UOP_SUM,        cond: COND_NEXT,    target: '0,        done: 1'b0};
      4'd12: w = '{op: UOP_FIN_UPD,    cond: COND_NEXT,    target: '0,        done: 1'b1};
      4'd13: w = '{op: UOP_FIN_SKIP,   cond: COND_NEXT,    target: '0,        done: 1'b1};
      4'd14: w = '{op: UOP_FIN_WR,     cond: COND_NEXT,    target: '0,        done: 1'b1};
      4'd15: w = '{op: UOP_FIN_NOP,    cond: COND_NEXT,    target: '0,        done: 1'b1};
      default: w = '{op: UOP_FIN_NOP,  cond: COND_NEXT,    target: '0,        done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* rtl/qla_in_if.sv */
// ----------------------------------------------------------------------------
// qla_in_if
// Request channel of the Q-table agent: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface qla_in_if;
  logic                            valid;
  logic                            ready;
  logic [qla_pkg::OpW-1:0]         opcode;
  logic [qla_pkg::StW-1:0]         state;
  logic signed [qla_pkg::StW-1:0]  next_state;
  logic [qla_pkg::ActW-1:0]        action;
  logic signed [qla_pkg::ValW-1:0] reward;
  logic signed [qla_pkg::ValW-1:0] write_value;
  logic [qla_pkg::RegW-1:0]        random_draw;
  logic [qla_pkg::PctW-1:0]        random_percent;

  modport source (
    output valid, opcode, state, next_state, action, reward, write_value,
           random_draw, random_percent,
    input  ready
  );
  modport sink (
    input  valid, opcode, state, next_state, action, reward, write_value,
           random_draw, random_percent,
    output ready
  );
endinterface

/* rtl/qla_out_if.sv */
// ----------------------------------------------------------------------------
// qla_out_if
// Result channel of the Q-table agent: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface qla_out_if;
  logic                            valid;
  logic                            ready;
  logic [qla_pkg::ActW-1:0]        chosen_action;
  logic                            explored;
  logic signed [qla_pkg::ValW-1:0] new_value;
  logic                            update_skipped;

  modport source (
    output valid, chosen_action, explored, new_value, update_skipped,
    input  ready
  );
  modport sink (
    input  valid, chosen_action, explored, new_value, update_skipped,
    output ready
  );
endinterface

/* rtl/q_learning_agent_table_top.sv */
// ----------------------------------------------------------------------------
// q_learning_agent_table_top
// Tabular Q-learning agent: epsilon-greedy choice, value update and table
// load, run by a small microcoded sequencer over one table memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per valid/ready handshake: choose (0),
//   update (1) or write (2). out_rsp returns exactly one result per request,
//   in order. The user must have the cfg port write epsilon, learning rate
//   and discount only while the block is idle; it does not enforce this.
// Sequencing:
//   One request is in flight at a time; the next is accepted once the
//   result is loaded. A greedy choose or a full update scans a row through
//   the single read port of the table (NUM_ACTIONS + 1 steps); a full
//   update then runs a three-step multiply chain.
// Reset:
//   Clears the sequencer and the result valid; presets the config registers.
//   Table entries are undefined until written; no clearing pass is run.
// Stall:
//   The result register holds while out_rsp.ready is low; a new request is
//   still taken, and its last step waits until the result register frees.
// ----------------------------------------------------------------------------
module q_learning_agent_table_top #(
  parameter int NUM_STATES  = 8,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qla_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [qla_pkg::RegW-1:0]         cfg_wdata_i,
  qla_in_if.sink                           in_req,
  qla_out_if.source                        out_rsp
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int AW    = SW + qla_pkg::ActW;
  localparam int Depth = NUM_STATES * (1 << qla_pkg::ActW);
  localparam logic [qla_pkg::StW:0]  NumStatesC = (qla_pkg::StW + 1)'(NUM_STATES);
  localparam logic [qla_pkg::ActW:0] NumActC    = (qla_pkg::ActW + 1)'(NUM_ACTIONS);
  localparam logic signed [50:0]     RoundHalf  = 51'sd2147483648;

  // Configuration registers
  logic [qla_pkg::RegW-1:0] explore_q, lrate_q, discount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explore_q  <= qla_pkg::ExploreRst;
      lrate_q    <= qla_pkg::LrateRst;
      discount_q <= qla_pkg::DiscountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qla_pkg::CFG_EXPLORE:  explore_q  <= cfg_wdata_i;
        qla_pkg::CFG_LRATE:    lrate_q    <= cfg_wdata_i;
        qla_pkg::CFG_DISCOUNT: discount_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic                    busy_q;
  qla_pkg::upc_t           upc_q, upc_d;
  logic [qla_pkg::ActW:0]  col_q;
  logic                    out_valid_q;
  qla_pkg::ctrl_t          ctrl;
  qla_pkg::in_item_t       item_q, item_in;
  qla_pkg::out_item_t      out_q, res_d;
  logic [SW-1:0]           row_q;
  qla_pkg::upc_t           entry_pc;

  // Datapath registers
  logic [qla_pkg::ValW-1:0]        rd_data_q;
  logic signed [qla_pkg::ValW-1:0] best_q, q_q;
  logic [qla_pkg::ActW-1:0]        best_idx_q;
  logic signed [32:0]              prod_g_q, phi_q;
  logic [32:0]                     plo_q;
  logic signed [33:0]              diff_q;
  logic signed [50:0]              delta_q;

  logic in_acc, advance, fin_go, taken;
  logic state_ok, act_ok, ns_ok, explore_c, skip_c, loop_c;
  logic [AW-1:0] entry_addr, scan_addr, rd_addr;
  logic mem_we;
  logic [qla_pkg::ValW-1:0] mem_wdata;
  logic signed [16:0] rq_diff;
  logic signed [19:0] upd_sum;
  logic signed [qla_pkg::ValW-1:0] upd_sat;
  logic [qla_pkg::ActW-1:0] expl_act;

  assign item_in = '{opcode: in_req.opcode, state: in_req.state,
                     next_state: in_req.next_state, action: in_req.action,
                     reward: in_req.reward, write_value: in_req.write_value,
                     random_draw: in_req.random_draw,
                     random_percent: in_req.random_percent};

  assign in_req.ready = !busy_q;
  assign in_acc       = in_req.valid && !busy_q;

  assign ctrl    = qla_pkg::ucode(upc_q);
  assign advance = !out_valid_q || out_rsp.ready;
  assign fin_go  = busy_q && ctrl.done && advance;

  always_comb begin
    case (in_req.opcode)
      qla_pkg::OP_CHOOSE: entry_pc = qla_pkg::EntryChoose;
      qla_pkg::OP_UPDATE: entry_pc = qla_pkg::EntryUpdate;
      qla_pkg::OP_WRITE:  entry_pc = qla_pkg::EntryWrite;
      default:            entry_pc = qla_pkg::EntryNop;
    endcase
  end

  // Index checks on the held request
  assign state_ok  = {1'b0, item_q.state} < NumStatesC;
  assign act_ok    = {1'b0, item_q.action} < NumActC;
  assign ns_ok     = !item_q.next_state[qla_pkg::StW-1] &&
                     ({1'b0, item_q.next_state} < NumStatesC);
  assign explore_c = !state_ok || (item_q.random_draw <= explore_q);
  assign skip_c    = !(state_ok && act_ok && ns_ok);
  assign loop_c    = col_q != NumActC;

  always_comb begin
    case (ctrl.cond)
      qla_pkg::COND_EXPLORE: taken = explore_c;
      qla_pkg::COND_SKIP:    taken = skip_c;
      qla_pkg::COND_LOOP:    taken = loop_c;
      default:               taken = 1'b0;
    endcase
    upc_d = taken ? ctrl.target : upc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        upc_q  <= entry_pc;
        col_q  <= '0;
      end else if (busy_q) begin
        if (ctrl.done) begin
          if (advance) begin
            busy_q <= 1'b0;
          end
        end else begin
          upc_q <= upc_d;
        end
        if (ctrl.op == qla_pkg::UOP_SCAN) begin
          col_q <= col_q + 1'b1;
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table memory: one write port, one registered read port
  logic [qla_pkg::ValW-1:0] mem_q [Depth];

  assign entry_addr = {item_q.state[SW-1:0], item_q.action};
  assign scan_addr  = {row_q, col_q[qla_pkg::ActW-1:0]};
  assign rd_addr    = (ctrl.op == qla_pkg::UOP_RDQ) ? entry_addr : scan_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[entry_addr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Update arithmetic
  assign rq_diff = $signed({item_q.reward[qla_pkg::ValW-1], item_q.reward}) -
                   $signed({q_q[qla_pkg::ValW-1], q_q});
  assign upd_sum = 20'(q_q) + 20'($signed(delta_q[50:32]));

  always_comb begin
    if (upd_sum > 20'sd32767) begin
      upd_sat = 16'sh7FFF;
    end else if (upd_sum < -20'sd32768) begin
      upd_sat = 16'sh8000;
    end else begin
      upd_sat = upd_sum[qla_pkg::ValW-1:0];
    end
  end

  always_comb begin
    if (item_q.random_percent < qla_pkg::PctLow) begin
      expl_act = 2'd0;
    end else if (item_q.random_percent < qla_pkg::PctHigh) begin
      expl_act = 2'd1;
    end else begin
      expl_act = 2'd2;
    end
  end

  // Result and table write of the final step
  always_comb begin
    res_d     = '0;
    mem_we    = 1'b0;
    mem_wdata = item_q.write_value;
    case (ctrl.op)
      qla_pkg::UOP_FIN_CHOOSE: res_d.chosen_action = best_idx_q;
      qla_pkg::UOP_FIN_EXPL: begin
        res_d.chosen_action = expl_act;
        res_d.explored      = 1'b1;
      end
      qla_pkg::UOP_FIN_UPD: begin
        res_d.new_value = upd_sat;
        mem_we          = fin_go;
        mem_wdata       = upd_sat;
      end
      qla_pkg::UOP_FIN_SKIP: res_d.update_skipped = 1'b1;
      qla_pkg::UOP_FIN_WR: begin
        if (state_ok && act_ok) begin
          res_d.new_value = item_q.write_value;
          mem_we          = fin_go;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_in;
      // choose scans the current state's row, update the next state's row
      row_q  <= (in_req.opcode == qla_pkg::OP_CHOOSE) ? in_req.state[SW-1:0]
                                                      : in_req.next_state[SW-1:0];
    end
    if (fin_go) begin
      out_q <= res_d;
    end
    if (busy_q) begin
      case (ctrl.op)
        qla_pkg::UOP_SCAN: begin
          // rd_data_q holds the element one column behind col_q
          if (col_q != '0) begin
            if (col_q == 3'd1 || $signed(rd_data_q) >= best_q) begin
              best_q     <= $signed(rd_data_q);
              best_idx_q <= qla_pkg::ActW'(col_q - 3'd1);
            end
          end
        end
        qla_pkg::UOP_MULG: begin
          q_q      <= $signed(rd_data_q);
          prod_g_q <= $signed({1'b0, discount_q}) * best_q;
        end
        qla_pkg::UOP_DIFF: diff_q <= 34'($signed({rq_diff, 16'h0000})) + 34'(prod_g_q);
        qla_pkg::UOP_MULL: plo_q  <= 33'(lrate_q) * 33'(diff_q[16:0]);
        qla_pkg::UOP_MULH: phi_q  <= $signed({1'b0, lrate_q}) * $signed(diff_q[33:17]);
        qla_pkg::UOP_SUM:  delta_q <= 51'($signed({phi_q, 17'h00000})) + 51'(plo_q)
                                      + RoundHalf;
        default: ;
      endcase
    end
  end

  assign out_rsp.valid          = out_valid_q;
  assign out_rsp.chosen_action  = out_q.chosen_action;
  assign out_rsp.explored       = out_q.explored;
  assign out_rsp.new_value      = out_q.new_value;
  assign out_rsp.update_skipped = out_q.update_skipped;

endmodule

/* dv/q_learning_agent_table_top_tb.sv */
// ----------------------------------------------------------------------------
// q_learning_agent_table_top_tb
// Self-checking bench for the Q-table agent. A queue of requests feeds a
// clocked driver on the request channel. Each accepted request runs through a
// local mirror of the value table and the three registers, and the outcome is
// queued. A clocked monitor compares every returned result, field by field,
// with the oldest queued outcome. A short directed sequence comes first. Six
// randomised phases follow, each with its own register setting and one of
// four idling patterns, and one phase includes a long receiver hold-off.
// ----------------------------------------------------------------------------
module q_learning_agent_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qla_pkg::*;

  localparam int NUM_ST      = 8;
  localparam int NUM_ACT     = 4;
  localparam int PHASES      = 6;
  localparam int PHASE_REQS  = 264;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;
  localparam int MAX_REPORTS = 100;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [OpW-1:0]        OpReserved = 2'd3;
  localparam logic signed [StW-1:0] EpisodeEnd = 4'sb1111;
  localparam logic signed [StW-1:0] NextBad    = 4'sb1000;
  localparam logic signed [ValW-1:0] ValMax    = 16'sh7fff;
  localparam logic signed [ValW-1:0] ValMin    = 16'sh8000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RegW-1:0]    cfg_wdata;

  qla_in_if  req_if ();
  qla_out_if rsp_if ();

  q_learning_agent_table_top #(
    .NUM_STATES  (NUM_ST),
    .NUM_ACTIONS (NUM_ACT)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_req      (req_if),
    .out_rsp     (rsp_if)
  );

  // Mirror of the block
  logic signed [ValW-1:0] q_mirror [NUM_ST][NUM_ACT];
  logic [RegW-1:0]        thr_reg  = ExploreRst;
  logic [RegW-1:0]        lr_reg   = LrateRst;
  logic [RegW-1:0]        disc_reg = DiscountRst;

  // Entries the stimulus has written so far
  bit gen_loaded [NUM_ST][NUM_ACT];

  in_item_t  req_backlog [$];
  out_item_t outcome_q   [$];
  in_item_t  cur_req;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_done      = 0;
  int hold_left      = 0;

  int n_queued   = 0;
  int n_checked  = 0;
  int n_err      = 0;
  int n_cycles   = 0;
  int n_explored = 0;
  int n_greedy   = 0;
  int n_updated  = 0;
  int n_skipped  = 0;
  int n_sat      = 0;
  int n_written  = 0;

  function automatic out_item_t agent_step(input in_item_t r);
    out_item_t              o;
    logic signed [ValW-1:0] best;
    longint                 q, mx, rw, g, lr, dif, dlt, sum;
    int                     ns, a;
    o  = '0;
    ns = $signed(r.next_state);
    case (r.opcode)
      OP_CHOOSE: begin
        if (r.state >= NUM_ST || r.random_draw <= thr_reg) begin
          o.explored = 1'b1;
          if (r.random_percent < PctLow) o.chosen_action = 2'd0;
          else if (r.random_percent < PctHigh) o.chosen_action = 2'd1;
          else o.chosen_action = 2'd2;
          n_explored++;
        end else begin
          // ties go to the later action
          best = q_mirror[r.state][0];
          for (a = 1; a < NUM_ACT; a++) begin
            if (q_mirror[r.state][a] >= best) begin
              best = q_mirror[r.state][a];
              o.chosen_action = a[ActW-1:0];
            end
          end
          n_greedy++;
        end
      end
      OP_UPDATE: begin
        if (ns < 0 || ns >= NUM_ST || r.state >= NUM_ST || r.action >= NUM_ACT) begin
          o.update_skipped = 1'b1;
          n_skipped++;
        end else begin
          q  = q_mirror[r.state][r.action];
          mx = q_mirror[ns][0];
          for (a = 1; a < NUM_ACT; a++) begin
            if (q_mirror[ns][a] > mx) mx = q_mirror[ns][a];
          end
          rw  = r.reward;
          g   = disc_reg;
          lr  = lr_reg;
          dif = rw * 65536 + g * mx - q * 65536;
          dlt = lr * dif;
          // round half up to Q3.12, then saturate
          sum = q + ((dlt + 64'sd2147483648) >>> 32);
          if (sum > 32767) begin
            sum = 32767;
            n_sat++;
          end else if (sum < -32768) begin
            sum = -32768;
            n_sat++;
          end
          q_mirror[r.state][r.action] = sum[ValW-1:0];
          o.new_value = sum[ValW-1:0];
          n_updated++;
        end
      end
      OP_WRITE: begin
        if (r.state < NUM_ST && r.action < NUM_ACT) begin
          q_mirror[r.state][r.action] = r.write_value;
          o.new_value = r.write_value;
          n_written++;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_item_t base_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t directed_req(input logic [OpW-1:0] op,
                                            input logic [StW-1:0] st,
                                            input logic signed [StW-1:0] ns,
                                            input logic [ActW-1:0] act,
                                            input logic signed [ValW-1:0] val,
                                            input logic [RegW-1:0] draw,
                                            input logic [PctW-1:0] pct);
    in_item_t r;
    r = base_req();
    r.opcode         = op;
    r.state          = st;
    r.next_state     = ns;
    r.action         = act;
    r.reward         = val;
    r.write_value    = val;
    r.random_draw    = draw;
    r.random_percent = pct;
    return r;
  endfunction

  function automatic bit row_loaded(input int s);
    int a;
    for (a = 0; a < NUM_ACT; a++) begin
      if (!gen_loaded[s][a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    logic signed [ValW-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(1) ? ValMax : ValMin;
      // narrow spread so that rows tie often
      2: v = $signed(16'($urandom_range(8))) - 16'sd4;
      default: v = $signed(16'($urandom_range(16383))) - 16'sd8192;
    endcase
    return v;
  endfunction

  function automatic in_item_t gen_req();
    in_item_t    r;
    int unsigned pick;
    int          d, ns, s, a;
    bit          blank;
    r    = base_req();
    pick = $urandom_range(99);
    if (pick < 40) r.opcode = OP_CHOOSE;
    else if (pick < 80) r.opcode = OP_UPDATE;
    else if (pick < 95) r.opcode = OP_WRITE;
    else r.opcode = OpReserved;
    r.state = ($urandom_range(99) < 12) ? $urandom_range(15, NUM_ST) : $urandom_range(NUM_ST - 1);
    pick = $urandom_range(99);
    if (pick < 8) r.next_state = EpisodeEnd;
    else if (pick >= 16) r.next_state = $urandom_range(NUM_ST - 1);
    r.reward      = pick_value();
    r.write_value = pick_value();
    pick = $urandom_range(99);
    if (pick < 20) begin
      // straddle the exploration boundary
      d = int'(thr_reg) + int'($urandom_range(2)) - 1;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      r.random_draw = d;
    end else if (pick < 30) begin
      r.random_draw = $urandom_range(1) ? 16'hffff : 16'h0000;
    end
    r.random_percent = ($urandom_range(99) < 90) ? $urandom_range(99) : $urandom_range(127);
    // never let the block read an entry that was not written yet
    ns    = $signed(r.next_state);
    blank = 1'b0;
    if (r.opcode == OP_CHOOSE && r.state < NUM_ST && r.random_draw > thr_reg &&
        !row_loaded(r.state)) blank = 1'b1;
    if (r.opcode == OP_UPDATE && r.state < NUM_ST && ns >= 0 && ns < NUM_ST &&
        (!gen_loaded[r.state][r.action] || !row_loaded(ns))) blank = 1'b1;
    if (blank) begin
      r.opcode = OP_WRITE;
      for (s = NUM_ST - 1; s >= 0; s--) begin
        for (a = NUM_ACT - 1; a >= 0; a--) begin
          if (!gen_loaded[s][a]) begin
            r.state  = s;
            r.action = a;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_req(input in_item_t r);
    if (r.opcode == OP_WRITE && r.state < NUM_ST && r.action < NUM_ACT)
      gen_loaded[r.state][r.action] = 1'b1;
    req_backlog.push_back(r);
    n_queued++;
  endfunction

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EXPLORE:  thr_reg  = val;
      CFG_LRATE:    lr_reg   = val;
      CFG_DISCOUNT: disc_reg = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (n_checked != n_queued) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d of %0d results checked", $time, n_checked, n_queued);
      $display("q_learning_agent_table_top_tb: done, errors");
      $finish;
    end
  end

  // Request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) outcome_q.push_back(agent_step(cur_req));
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_backlog.pop_front();
          req_if.valid          <= 1'b1;
          req_if.opcode         <= cur_req.opcode;
          req_if.state          <= cur_req.state;
          req_if.next_state     <= cur_req.next_state;
          req_if.action         <= cur_req.action;
          req_if.reward         <= cur_req.reward;
          req_if.write_value    <= cur_req.write_value;
          req_if.random_draw    <= cur_req.random_draw;
          req_if.random_percent <= cur_req.random_percent;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result act=%0d expl=%0b val=%0d skip=%0b", $time,
                   rsp_if.chosen_action, rsp_if.explored, rsp_if.new_value,
                   rsp_if.update_skipped);
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (rsp_if.chosen_action !== want.chosen_action ||
              rsp_if.explored !== want.explored ||
              rsp_if.new_value !== want.new_value ||
              rsp_if.update_skipped !== want.update_skipped) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
              $display("%0t: mismatch, expected act=%0d expl=%0b val=%0d skip=%0b, got act=%0d expl=%0b val=%0d skip=%0b",
                       $time, want.chosen_action, want.explored, $signed(want.new_value),
                       want.update_skipped, rsp_if.chosen_action, rsp_if.explored,
                       rsp_if.new_value, rsp_if.update_skipped);
          end
        end
      end
      // hold ready low for a long stretch when asked, else stall at random
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int k, ph;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_EXPLORE;
    cfg_wdata             = '0;
    req_if.valid          = 1'b0;
    req_if.opcode         = OP_CHOOSE;
    req_if.state          = '0;
    req_if.next_state     = '0;
    req_if.action         = '0;
    req_if.reward         = '0;
    req_if.write_value    = '0;
    req_if.random_draw    = '0;
    req_if.random_percent = '0;
    rsp_if.ready          = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: row 0 holds two tied maxima, so greedy picks the later one
    queue_req(directed_req(OP_WRITE, 4'd0, 4'sd0, 2'd0, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_WRITE, 4'd0, 4'sd0, 2'd1, ValMin, 16'd0, 7'd0));
    queue_req(directed_req(OP_WRITE, 4'd0, 4'sd0, 2'd2, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_WRITE, 4'd0, 4'sd0, 2'd3, ValMin, 16'd0, 7'd0));
    queue_req(directed_req(OP_CHOOSE, 4'd0, 4'sd0, 2'd0, 16'sd0, 16'hffff, 7'd99));
    queue_req(directed_req(OP_CHOOSE, 4'd0, 4'sd0, 2'd0, 16'sd0, ExploreRst, 7'd0));
    queue_req(directed_req(OP_CHOOSE, 4'd0, 4'sd0, 2'd0, 16'sd0, ExploreRst + 16'd1, 7'd0));
    queue_req(directed_req(OP_CHOOSE, 4'd15, 4'sd0, 2'd0, 16'sd0, 16'hffff, 7'd29));
    queue_req(directed_req(OP_CHOOSE, 4'd8, 4'sd0, 2'd0, 16'sd0, 16'hffff, 7'd30));
    queue_req(directed_req(OP_CHOOSE, 4'd15, 4'sd0, 2'd0, 16'sd0, 16'h0000, 7'd84));
    queue_req(directed_req(OP_CHOOSE, 4'd15, 4'sd0, 2'd0, 16'sd0, 16'h0000, 7'd85));
    queue_req(directed_req(OP_CHOOSE, 4'd15, 4'sd0, 2'd0, 16'sd0, 16'h0000, 7'd127));
    queue_req(directed_req(OP_UPDATE, 4'd0, EpisodeEnd, 2'd0, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_UPDATE, 4'd0, NextBad, 2'd0, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_UPDATE, 4'd9, 4'sd0, 2'd0, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_UPDATE, 4'd0, 4'sd0, 2'd1, ValMax, 16'd0, 7'd0));
    queue_req(directed_req(OP_UPDATE, 4'd0, 4'sd0, 2'd3, ValMin, 16'd0, 7'd0));
    queue_req(directed_req(OP_WRITE, 4'd12, 4'sd0, 2'd0, 16'sh1234, 16'd0, 7'd0));
    queue_req(directed_req(OpReserved, 4'd0, 4'sd0, 2'd0, 16'sh1234, 16'd0, 7'd0));
    queue_req(directed_req(OP_WRITE, 4'd7, 4'sd0, 2'd3, 16'sh1234, 16'd0, 7'd0));
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          set_reg(CFG_EXPLORE, 16'd0);
          set_reg(CFG_LRATE, 16'hffff);
          set_reg(CFG_DISCOUNT, 16'hffff);
        end
        1: begin
          set_reg(CFG_EXPLORE, 16'hffff);
          set_reg(CFG_LRATE, 16'd0);
          set_reg(CFG_DISCOUNT, 16'd0);
        end
        2: begin
          set_reg(CFG_EXPLORE, 16'h8000);
          set_reg(CFG_LRATE, 16'h8000);
          set_reg(CFG_DISCOUNT, DiscountRst);
        end
        3: begin
          set_reg(CFG_EXPLORE, $urandom);
          set_reg(CFG_LRATE, $urandom);
          set_reg(CFG_DISCOUNT, $urandom);
        end
        4: begin
          set_reg(CFG_EXPLORE, 16'd1);
          set_reg(CFG_LRATE, 16'hffff);
          set_reg(CFG_DISCOUNT, 16'd0);
        end
        default: begin
          set_reg(CFG_EXPLORE, $urandom);
          set_reg(CFG_LRATE, 16'd1);
          set_reg(CFG_DISCOUNT, 16'hffff);
        end
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      // back up the block behind a stalled receiver
      if (ph == 0) hold_asked++;
      for (k = 0; k < PHASE_REQS / 2; k++) queue_req(gen_req());
      drain();
      // resume once the block has gone quiet
      for (k = 0; k < PHASE_REQS / 2; k++) queue_req(gen_req());
      drain();
    end

    if (outcome_q.size() != 0) begin
      n_err++;
      $display("%0t: %0d results never returned", $time, outcome_q.size());
    end
    $display("Covered %0d requests over %0d register settings: %0d explored, %0d greedy,",
             n_queued, PHASES + 1, n_explored, n_greedy);
    $display("%0d updates (%0d saturated), %0d skipped, %0d writes; %0d failures",
             n_updated, n_sat, n_skipped, n_written, n_err);
    if (n_err == 0) begin
      $display("q_learning_agent_table_top_tb: done, clean");
    end else begin
      $display("q_learning_agent_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
